### rtl/core/gop4_pkg.sv
// Shared types and constants for the 4x4 outer-product GEMM tile.
package gop4_pkg;

	localparam int TILE          = 4;
	localparam int DATA_W        = 16;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int ACC_W         = 48;
	localparam int ROW_W         = $clog2(TILE);
	localparam int PRELOAD_SHIFT = 8;

	localparam logic CMD_PRELOAD = 1'b0;
	localparam logic CMD_ACC     = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef data_t [TILE-1:0]         data_row_t;
	typedef acc_t [TILE-1:0]          acc_row_t;
	typedef acc_row_t [TILE-1:0]      acc_tile_t;

	typedef struct packed {
		logic             cmd;
		logic [ROW_W-1:0] row;
		data_t            a_row0;
		data_t            a_row1;
		data_t            a_row2;
		data_t            a_row3;
		data_t            b_col0;
		data_t            b_col1;
		data_t            b_col2;
		data_t            b_col3;
		logic             last_step;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		acc_t             c_col0;
		acc_t             c_col1;
		acc_t             c_col2;
		acc_t             c_col3;
		logic             last_row;
	} result_t;

	typedef struct packed {
		logic capture;
		logic commit_acc;
		logic commit_pre;
	} lane_ctrl_t;

endpackage

### rtl/core/gop4_lane.sv
// One accumulator row: four registered multipliers feeding four 48-bit accumulators.
module gop4_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gop4_pkg::lane_ctrl_t  ctrl,
	input  gop4_pkg::data_t       a,
	input  gop4_pkg::data_row_t   b,
	input  gop4_pkg::data_row_t   pre,
	output gop4_pkg::acc_row_t    sum
);
	import gop4_pkg::*;

	prod_t prod_s1 [TILE];
	acc_t  acc_q   [TILE];

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			for (int j = 0; j < TILE; j++) begin
				prod_s1[j] <= $signed(a) * $signed(b[j]);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < TILE; j++) begin
			sum[j] = acc_q[j] + acc_t'(prod_s1[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TILE; j++) begin
				acc_q[j] <= '0;
			end
		end else if (ctrl.commit_acc) begin
			for (int j = 0; j < TILE; j++) begin
				acc_q[j] <= sum[j];
			end
		end else if (ctrl.commit_pre) begin
			// Q8.8 -> Q32.16
			for (int j = 0; j < TILE; j++) begin
				acc_q[j] <= acc_t'($signed(pre[j])) <<< PRELOAD_SHIFT;
			end
		end
	end

endmodule

### rtl/core/gop4_emit.sv
// Output stage: snapshots the finished tile and drains it one row per transaction.
module gop4_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 snap,
	input  gop4_pkg::acc_tile_t  rows,
	output logic                 busy,
	output logic                 result_valid,
	input  logic                 result_stall,
	output gop4_pkg::result_t    result
);
	import gop4_pkg::*;

	acc_row_t         buf_q [TILE];
	logic [ROW_W-1:0] cnt_q;
	logic             valid_q;
	logic             take;

	assign take         = valid_q && !result_stall;
	assign busy         = valid_q;
	assign result_valid = valid_q;

	always_comb begin
		result.out_row  = cnt_q;
		result.c_col0   = buf_q[0][0];
		result.c_col1   = buf_q[0][1];
		result.c_col2   = buf_q[0][2];
		result.c_col3   = buf_q[0][3];
		result.last_row = (cnt_q == ROW_W'(TILE - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (snap) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ROW_W'(TILE - 1)) begin
				valid_q <= 1'b0;
			end
		end
	end

	// rows shift toward slot 0 as they are taken
	always_ff @(posedge clk) begin
		if (snap) begin
			for (int k = 0; k < TILE; k++) begin
				buf_q[k] <= rows[k];
			end
		end else if (take) begin
			for (int k = 0; k < TILE - 1; k++) begin
				buf_q[k] <= buf_q[k + 1];
			end
		end
	end

endmodule

### rtl/core/gemm_4x4_outer_product_tile.sv
// A last accumulate step passes stage 1, then the output buffer shows its first row.
// Throughput: one item per cycle unless stalled; the four multiplier lanes take a column
// pair each cycle. A tile drains at one row per cycle unless result_stall is set; a last
// step waits in stage 1 while the previous tile is still draining from the output buffer.
// Reset clears the accumulators to zero and empties the pipeline and output buffer.
module gemm_4x4_outer_product_tile (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  gop4_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output gop4_pkg::result_t  result
);
	import gop4_pkg::*;

	logic             valid_s1;
	logic             cmd_s1;
	logic [ROW_W-1:0] row_s1;
	logic             last_s1;
	data_row_t        pre_s1;

	logic       accept;
	logic       hold;
	logic       commit;
	logic       snap;
	logic       busy;
	data_row_t  a_vec;
	data_row_t  b_vec;
	acc_tile_t  sums;
	lane_ctrl_t ctrl [TILE];

	assign a_vec = {item.a_row3, item.a_row2, item.a_row1, item.a_row0};
	assign b_vec = {item.b_col3, item.b_col2, item.b_col1, item.b_col0};

	// a last step cannot commit until the output buffer is free
	assign hold       = valid_s1 && (cmd_s1 == CMD_ACC) && last_s1 && busy;
	assign commit     = valid_s1 && !hold;
	assign item_stall = hold;
	assign accept     = item_valid && !item_stall;
	assign snap       = commit && (cmd_s1 == CMD_ACC) && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= item.cmd;
			row_s1  <= item.row;
			last_s1 <= item.last_step;
			pre_s1  <= b_vec;
		end
	end

	for (genvar i = 0; i < TILE; i++) begin : g_lane
		always_comb begin
			ctrl[i].capture    = accept;
			ctrl[i].commit_acc = commit && (cmd_s1 == CMD_ACC);
			ctrl[i].commit_pre = commit && (cmd_s1 == CMD_PRELOAD)
				&& (row_s1 == ROW_W'(i));
		end

		gop4_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl[i]),
			.a      (a_vec[i]),
			.b      (b_vec),
			.pre    (pre_s1),
			.sum    (sums[i])
		);
	end

	gop4_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap         (snap),
		.rows         (sums),
		.busy         (busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTH
	a_snap_free: assert property (@(posedge clk) disable iff (!arst_n)
		snap |-> !busy)
		else $error("tile snapshot while output buffer busy");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && last_s1 && result_valid))
		else $error("input stalled without a pending last step");

	a_drain_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !result.last_row) |=> result_valid)
		else $error("tile drain stopped before last row");

	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !result.last_row)
		|=> (result.out_row == ROW_W'($past(result.out_row) + 1'b1)))
		else $error("output rows out of order");
`endif

endmodule

### dv/tb_gemm_4x4_outer_product_tile.sv
// Testbench for the 4x4 outer-product GEMM tile: directed and random transactions, rows checked in order.
`timescale 1ns / 1ps
module tb_gemm_4x4_outer_product_tile;
	import gop4_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	// Full-scale steps of (-128.0 * -128.0) = 2^30, enough to push sums past 32 bits
	localparam int EXTREME_STEPS = 12;

	localparam data_t D_MIN  = data_t'(16'h8000);
	localparam data_t D_MAX  = data_t'(16'h7fff);
	localparam data_t D_ZERO = data_t'(16'h0000);
	localparam data_t D_ONE  = data_t'(16'h0100);
	localparam data_t D_NEG1 = data_t'(16'hffff);

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	acc_t    tile_acc [TILE][TILE];
	result_t exp_rows_q [$];
	int      err_cnt = 0;
	int      items_sent = 0;
	int      quiet_cycles = 0;
	bit      tx_gaps = 1'b0;
	bit      rx_gaps = 1'b0;
	int      rx_hold = 0;

	gemm_4x4_outer_product_tile dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #10 clk = ~clk;

	// Apply one accepted transaction to the tile and queue the rows it emits.
	task automatic apply_to_tile(input item_t it);
		data_t   a_v [TILE];
		data_t   b_v [TILE];
		prod_t   p;
		result_t r;
		a_v = '{it.a_row0, it.a_row1, it.a_row2, it.a_row3};
		b_v = '{it.b_col0, it.b_col1, it.b_col2, it.b_col3};
		if (it.cmd == CMD_PRELOAD) begin
			for (int j = 0; j < TILE; j++)
				tile_acc[it.row][j] = acc_t'(b_v[j]) <<< PRELOAD_SHIFT;
			return;
		end
		for (int i = 0; i < TILE; i++)
			for (int j = 0; j < TILE; j++) begin
				p = a_v[i] * b_v[j];
				tile_acc[i][j] = tile_acc[i][j] + p;
			end
		if (it.last_step) begin
			for (int i = 0; i < TILE; i++) begin
				r.out_row  = ROW_W'(i);
				r.c_col0   = tile_acc[i][0];
				r.c_col1   = tile_acc[i][1];
				r.c_col2   = tile_acc[i][2];
				r.c_col3   = tile_acc[i][3];
				r.last_row = (i == TILE - 1);
				exp_rows_q.push_back(r);
			end
		end
	endtask

	function automatic item_t mk_item(logic cmd, logic [ROW_W-1:0] row,
		data_t a0, data_t a1, data_t a2, data_t a3,
		data_t b0, data_t b1, data_t b2, data_t b3, logic last);
		return '{cmd, row, a0, a1, a2, a3, b0, b1, b2, b3, last};
	endfunction

	// Biased toward the extremes of Q8.8
	function automatic data_t rand_data();
		case ($urandom_range(0, 7))
			0: return D_MIN;
			1: return D_MAX;
			2: return D_ZERO;
			3: return D_NEG1;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic item_t rand_item(logic cmd, logic last);
		return mk_item(cmd, ROW_W'($urandom), rand_data(), rand_data(), rand_data(),
			rand_data(), rand_data(), rand_data(), rand_data(), rand_data(), last);
	endfunction

	task automatic send_item(input item_t it);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		apply_to_tile(it);
		items_sent++;
	endtask

	// Optional preloads, then a run of accumulate steps closed by a last step.
	task automatic send_rand_tile(input int steps);
		for (int r = 0; r < TILE; r++)
			if ($urandom_range(0, 1))
				send_item(rand_item(CMD_PRELOAD, 1'($urandom)));
		for (int k = 1; k <= steps; k++)
			send_item(rand_item(CMD_ACC, logic'(k == steps)));
	endtask

	task automatic wait_rows_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (exp_rows_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		// preloads carry junk A fields, some with a set last flag; nothing may come out
		send_item(mk_item(CMD_PRELOAD, 2'd0, D_MAX, D_MIN, D_NEG1, D_MAX,
			D_MAX, D_MIN, D_ZERO, D_NEG1, 1'b1));
		send_item(mk_item(CMD_PRELOAD, 2'd1, D_MIN, D_MIN, D_MIN, D_MIN,
			D_MIN, D_MIN, D_MIN, D_MIN, 1'b0));
		send_item(mk_item(CMD_PRELOAD, 2'd2, D_ONE, D_ZERO, D_MAX, D_MIN,
			D_MAX, D_MAX, D_MAX, D_MAX, 1'b1));
		send_item(mk_item(CMD_PRELOAD, 2'd3, D_ZERO, D_ZERO, D_ZERO, D_ZERO,
			D_NEG1, D_ZERO, D_MAX, D_MIN, 1'b0));
		send_item(mk_item(CMD_ACC, 2'd0, D_MIN, D_MAX, D_ZERO, D_NEG1,
			D_MIN, D_MAX, D_NEG1, D_ONE, 1'b0));
		send_item(mk_item(CMD_ACC, 2'd3, D_MIN, D_MIN, D_MIN, D_MIN,
			D_MIN, D_MIN, D_MIN, D_MIN, 1'b1));
		// emission leaves the tile intact, so the next tile builds on it
		send_item(mk_item(CMD_ACC, 2'd1, D_MAX, D_MAX, D_MAX, D_MAX,
			D_MIN, D_MIN, D_MIN, D_MIN, 1'b1));
		send_item(mk_item(CMD_ACC, 2'd2, D_ZERO, D_ZERO, D_ZERO, D_ZERO,
			D_ZERO, D_ZERO, D_ZERO, D_ZERO, 1'b1));
		send_item(mk_item(CMD_PRELOAD, 2'd3, D_NEG1, D_NEG1, D_NEG1, D_NEG1,
			D_ONE, D_NEG1, D_MIN, D_MAX, 1'b1));
		send_item(mk_item(CMD_ACC, 2'd0, D_ONE, D_NEG1, D_MAX, D_MIN,
			D_ONE, D_ONE, D_NEG1, D_NEG1, 1'b0));
		send_item(mk_item(CMD_ACC, 2'd1, D_NEG1, D_ONE, D_MIN, D_MAX,
			D_MAX, D_ZERO, D_MIN, D_ONE, 1'b1));
		wait_rows_drained();
	endtask

	task automatic test_random_tiles();
		int target;
		target  = items_sent + 200;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		while (items_sent < target) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4))
					send_item(rand_item(1'($urandom), 1'($urandom)));
			end else begin
				send_rand_tile($urandom_range(1, 6));
			end
		end
		wait_rows_drained();
	endtask

	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		rx_hold = 120;
		// every step closes a tile, so the output backs up and the input has to stall
		repeat (24) send_item(rand_item(CMD_ACC, 1'b1));
		wait_rows_drained();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		repeat (4) send_rand_tile($urandom_range(1, 4));
		wait_rows_drained();
	endtask

	task automatic test_acc_extremes();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (int r = 0; r < TILE; r++)
			send_item(mk_item(CMD_PRELOAD, ROW_W'(r), D_ZERO, D_ZERO, D_ZERO, D_ZERO,
				D_MAX, D_MIN, D_MAX, D_MIN, 1'b0));
		// rows come out every third step as the sums grow past 32 bits
		for (int n = 1; n <= EXTREME_STEPS; n++)
			send_item(mk_item(CMD_ACC, 2'd0, D_MIN, D_MIN, D_MIN, D_MIN,
				D_MIN, D_MIN, D_MIN, D_MIN, logic'(n % 3 == 0)));
		wait_rows_drained();
	endtask

	task automatic test_no_idling();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (8) send_rand_tile($urandom_range(1, 4));
		wait_rows_drained();
	endtask

	initial begin
		foreach (tile_acc[i, j]) tile_acc[i][j] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_tiles();
		test_backpressure();
		test_acc_extremes();
		test_no_idling();
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("tb_gemm_4x4_outer_product_tile: clean");
		end else begin
			$display("tb_gemm_4x4_outer_product_tile: errors");
		end
		$finish;
	end

	// Receiver: random stall bursts, or one long hold when a test asks for it
	initial begin : rx_side
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				n       = rx_hold;
				rx_hold = 0;
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(input string fname, input logic signed [ACC_W-1:0] want,
		input logic signed [ACC_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin : row_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (exp_rows_q.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, result);
				err_cnt++;
			end else begin
				want = exp_rows_q.pop_front();
				check_field("out_row", ACC_W'(want.out_row), ACC_W'(result.out_row));
				check_field("c_col0", want.c_col0, result.c_col0);
				check_field("c_col1", want.c_col1, result.c_col1);
				check_field("c_col2", want.c_col2, result.c_col2);
				check_field("c_col3", want.c_col3, result.c_col3);
				check_field("last_row", ACC_W'(want.last_row), ACC_W'(result.last_row));
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_gemm_4x4_outer_product_tile: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
